// File: rtl/thph_pkg.sv
// ============================================================================
// thph_pkg
// Shared types and constants for the track pulse height statistics unit.
// ============================================================================
package thph_pkg;

    // default chain length limit
    localparam int MAX_SEGMENTS_DEF = 256;

    // input field widths
    localparam int PH_W     = 31;
    localparam int SLOPE_W  = 21;
    localparam int PLATE_W  = 10;

    // pulse height reduction: quotient by reciprocal multiply, then remainder
    // 10000 = 16 * 625, and floor(y / 625) = (y * ceil(2^36 / 625)) >> 36
    // holds for every y below 2^27
    localparam int MOD_W     = 32;
    localparam int MOD_STEPS = 2;
    localparam int STEP_W    = 1;
    localparam int PH_DROP   = 4;
    localparam int RECIP_W   = 27;
    localparam int RECIP_SH  = 36;
    localparam int PHQ_W     = 18;
    localparam int PROD_W    = (PH_W - PH_DROP) + RECIP_W;
    localparam int PHR_W     = 14;
    localparam int PHS_W     = 15;
    localparam int PHSQ_W    = 30;
    localparam logic [MOD_W-1:0]   PH_MODULUS = 32'd10000;
    localparam logic [RECIP_W-1:0] PH_RECIP   = 27'd109951163;

    // output field widths
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int SPAN_W   = 11;
    localparam int MEAN_W   = 23;
    localparam int SD_W     = 22;
    localparam int ANGLE_W  = 21;
    localparam logic [SD_W-1:0] SD_MAX = 22'h3FFFFF;

    // stream payload widths
    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 136;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (STATUS_W + COUNT_W + SPAN_W + MEAN_W + SD_W
                                                + 2 * SLOPE_W + ANGLE_W);

    // configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MINC_W     = 8;
    localparam int VFLOOR_W   = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VAR_FLOOR = 2'd1;
    localparam logic [MINC_W-1:0]    MINC_RESET    = 8'd2;
    localparam logic [VFLOOR_W-1:0]  VFLOOR_RESET  = 16'd26;

    typedef enum logic [1:0] {
        ST_KEPT   = 2'd0,
        ST_FEW    = 2'd1,
        ST_LOWVAR = 2'd2,
        ST_MANY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MOD,
        F_ACC
    } t_front_state;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL,
        B_DEV,
        B_DIV_VAR,
        B_DIV_MEAN,
        B_DIV_MX,
        B_DIV_MY,
        B_ANG_SQ,
        B_SQRT_ANG,
        B_DIV_SD,
        B_SQRT_SD,
        B_DONE
    } t_back_state;

endpackage

// File: rtl/track_pulse_height_statistics_unit.sv
// ============================================================================
// track_pulse_height_statistics_unit
// Running pulse height mean and sample deviation over the segments of a chain.
// ============================================================================
// Segments arrive on the s_axis stream, one request per segment, with tlast
// on the final segment of a chain. Each chain yields one result on m_axis.
// Settings come in on the cfg write channel (index 0: minimum count, index 1:
// variance floor), which is always ready; write them while the unit is idle.
// Input side: a segment is taken, then F_MOD reduces both pulse heights
// mod 10000 (reciprocal multiply for the quotient, then the remainder) and
// F_ACC adds it to the chain sums; the front takes no new segment until
// F_ACC is done, and F_ACC waits while a last segment finds the queue full.
// On tlast the chain sums go into a two entry queue and the back end works
// them off: one shift-add multiply, up to five divisions on one shared
// divider and up to two square roots.
// The result waits in an output register while m_axis_tready is low; the
// front keeps taking segments until a last segment finds the queue full.
// Reset clears the chain sums, empties the queue and loads the default settings.
module track_pulse_height_statistics_unit #(
    parameter int MAX_SEGMENTS = thph_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // segment stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // pulse_height_a, pulse_height_b, slope_x, slope_y, plate, zero fill
    input  logic [thph_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                 s_axis_tlast,
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // status, segment_count, plate_span, mean_pulse_height, sd_pulse_height,
    // mean_slope_x, mean_slope_y, angle_magnitude, zero fill
    output logic [thph_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [thph_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [thph_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import thph_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int SUM_W  = PHS_W + CNT_W;
    localparam int SQ_W   = PHSQ_W + CNT_W;
    localparam int SS_W   = SLOPE_W + CNT_W;
    localparam int SNAP_W = 1 + CNT_W + SPAN_W + SUM_W + SQ_W + 2 * SS_W;

    logic [MINC_W-1:0]   r_min_count;
    logic [VFLOOR_W-1:0] r_var_floor;

    logic                push;
    logic [SNAP_W-1:0]   snap_in;
    logic                q_full;
    logic                pop;
    logic                q_valid;
    logic [SNAP_W-1:0]   snap_out;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_count <= MINC_RESET;
            r_var_floor <= VFLOOR_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_MIN_COUNT) begin
                r_min_count <= i_cfg_data[MINC_W-1:0];
            end else if (i_cfg_index == CFG_VAR_FLOOR) begin
                r_var_floor <= i_cfg_data[VFLOOR_W-1:0];
            end
        end
    end

    thph_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_pulse_height_a (s_axis_tdata[30:0]),
        .i_pulse_height_b (s_axis_tdata[61:31]),
        .i_slope_x        (s_axis_tdata[82:62]),
        .i_slope_y        (s_axis_tdata[103:83]),
        .i_plate          (s_axis_tdata[113:104]),
        .i_last_segment   (s_axis_tlast),
        .o_push           (push),
        .o_snap           (snap_in),
        .i_full           (q_full)
    );

    thph_fifo #(
        .W     (SNAP_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (snap_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (snap_out)
    );

    thph_back #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (q_valid),
        .i_snap       (snap_out),
        .o_pop        (pop),
        .i_min_count  (r_min_count),
        .i_var_floor  (r_var_floor),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata)
    );

endmodule

// File: rtl/thph_fifo.sv
// ============================================================================
// thph_fifo
// Small register queue holding finished chain sums between front and back.
// ============================================================================
module thph_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/thph_div.sv
// ============================================================================
// thph_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ============================================================================
module thph_div #(
    parameter int DVD_W = 64,
    parameter int DVS_W = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);
    localparam int C_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [C_W-1:0]   r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_diff;
    logic             ge;

    // one compare and subtract step
    always_comb begin
        rem_sh   = {r_rem, r_dvd[DVD_W-1]};
        rem_diff = rem_sh - {1'b0, r_dvs};
        ge       = (rem_sh >= {1'b0, r_dvs});
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= C_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - C_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient shifts in where the dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], ge};
            r_rem <= ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

endmodule

// File: rtl/thph_sqrt.sv
// ============================================================================
// thph_sqrt
// Digit by digit integer square root, one root bit per cycle.
// ============================================================================
module thph_sqrt #(
    parameter int IN_W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [IN_W-1:0]   i_radicand,
    output logic              o_done,
    output logic [IN_W/2-1:0] o_root
);
    localparam int RT_W = IN_W / 2;
    localparam int C_W  = $clog2(RT_W);

    logic            r_busy;
    logic            r_done;
    logic [C_W-1:0]  r_cnt;
    logic [IN_W-1:0] r_x;
    logic [RT_W-1:0] r_root;
    logic [RT_W+1:0] r_rem;
    logic [RT_W+3:0] rem_sh;
    logic [RT_W+3:0] trial;
    logic [RT_W+3:0] rem_diff;
    logic            ge;

    // bring down two bits, try root*4+1
    always_comb begin
        rem_sh   = {r_rem, r_x[IN_W-1:IN_W-2]};
        trial    = {2'b00, r_root, 2'b01};
        rem_diff = rem_sh - trial;
        ge       = (rem_sh >= trial);
    end

    assign o_done = r_done;
    assign o_root = r_root;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= C_W'(RT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - C_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[IN_W-3:0], 2'b00};
            r_root <= {r_root[RT_W-2:0], ge};
            r_rem  <= ge ? rem_diff[RT_W+1:0] : rem_sh[RT_W+1:0];
        end
    end

endmodule

// File: rtl/thph_front.sv
// ============================================================================
// thph_front
// Takes segments, reduces pulse heights mod 10000 and accumulates chain sums.
// ============================================================================
module thph_front #(
    parameter int MAX_SEGMENTS = thph_pkg::MAX_SEGMENTS_DEF,
    parameter int CNT_W  = $clog2(MAX_SEGMENTS + 1),
    parameter int SUM_W  = thph_pkg::PHS_W + CNT_W,
    parameter int SQ_W   = thph_pkg::PHSQ_W + CNT_W,
    parameter int SS_W   = thph_pkg::SLOPE_W + CNT_W,
    parameter int SNAP_W = 1 + CNT_W + thph_pkg::SPAN_W + SUM_W + SQ_W + 2 * SS_W
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [thph_pkg::PH_W-1:0]            i_pulse_height_a,
    input  logic [thph_pkg::PH_W-1:0]            i_pulse_height_b,
    input  logic signed [thph_pkg::SLOPE_W-1:0]  i_slope_x,
    input  logic signed [thph_pkg::SLOPE_W-1:0]  i_slope_y,
    input  logic [thph_pkg::PLATE_W-1:0]         i_plate,
    input  logic                                 i_last_segment,
    output logic                                 o_push,
    output logic [SNAP_W-1:0]                    o_snap,
    input  logic                                 i_full
);
    import thph_pkg::*;

    t_front_state r_state;
    t_front_state n_state;

    // segment being worked on
    logic [PH_W-1:0]           r_pa;
    logic [PH_W-1:0]           r_pb;
    logic signed [SLOPE_W-1:0] r_sx;
    logic signed [SLOPE_W-1:0] r_sy;
    logic [PLATE_W-1:0]        r_plate;
    logic                      r_last;
    logic [STEP_W-1:0]         r_step;
    logic [PHQ_W-1:0]          r_qa;
    logic [PHQ_W-1:0]          r_qb;

    // chain sums
    logic [CNT_W-1:0]        r_cnt;
    logic [SUM_W-1:0]        r_sum;
    logic [SQ_W-1:0]         r_sq;
    logic signed [SS_W-1:0]  r_sx_sum;
    logic signed [SS_W-1:0]  r_sy_sum;
    logic [PLATE_W-1:0]      r_first;
    logic                    r_ovf;

    logic [PROD_W-1:0]       qa_prod;
    logic [PROD_W-1:0]       qb_prod;
    logic [PH_W-1:0]         pa_nxt;
    logic [PH_W-1:0]         pb_nxt;
    logic [PHS_W-1:0]        ph;
    logic [PHSQ_W-1:0]       ph_sq;
    logic [CNT_W-1:0]        a_cnt;
    logic [SUM_W-1:0]        a_sum;
    logic [SQ_W-1:0]         a_sq;
    logic signed [SS_W-1:0]  a_sx;
    logic signed [SS_W-1:0]  a_sy;
    logic [PLATE_W-1:0]      a_first;
    logic                    a_ovf;
    logic [SPAN_W-1:0]       span;
    logic                    acc_go;

    // quotient by reciprocal multiply, remainder from the registered quotient
    always_comb begin
        qa_prod = PROD_W'(r_pa[PH_W-1:PH_DROP]) * PROD_W'(PH_RECIP);
        qb_prod = PROD_W'(r_pb[PH_W-1:PH_DROP]) * PROD_W'(PH_RECIP);
        pa_nxt  = r_pa - PH_W'(r_qa) * PH_W'(PH_MODULUS);
        pb_nxt  = r_pb - PH_W'(r_qb) * PH_W'(PH_MODULUS);
    end

    // summed pulse height and its square
    always_comb begin
        ph    = PHS_W'(r_pa[PHR_W-1:0]) + PHS_W'(r_pb[PHR_W-1:0]);
        ph_sq = {{(PHSQ_W-PHS_W){1'b0}}, ph} * {{(PHSQ_W-PHS_W){1'b0}}, ph};
    end

    // accumulate, or flag overflow once the chain is full
    always_comb begin
        a_cnt   = r_cnt;
        a_sum   = r_sum;
        a_sq    = r_sq;
        a_sx    = r_sx_sum;
        a_sy    = r_sy_sum;
        a_first = r_first;
        a_ovf   = r_ovf;
        if (r_cnt == CNT_W'(MAX_SEGMENTS)) begin
            a_ovf = 1'b1;
        end else begin
            if (r_cnt == '0) begin
                a_first = r_plate;
            end
            a_cnt = r_cnt + CNT_W'(1);
            a_sum = r_sum + SUM_W'(ph);
            a_sq  = r_sq + SQ_W'(ph_sq);
            a_sx  = r_sx_sum + SS_W'(r_sx);
            a_sy  = r_sy_sum + SS_W'(r_sy);
        end
        span = (r_plate >= a_first) ? SPAN_W'(r_plate - a_first) + SPAN_W'(1)
                                    : SPAN_W'(a_first - r_plate) + SPAN_W'(1);
    end

    assign o_snap = {a_ovf, a_cnt, span, a_sum, a_sq, a_sx, a_sy};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        acc_go  = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = F_MOD;
                end
            end
            F_MOD: begin
                if (r_step == '0) begin
                    n_state = F_ACC;
                end
            end
            F_ACC: begin
                if (!r_last || !i_full) begin
                    acc_go  = 1'b1;
                    o_push  = r_last;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    // segment registers and reduction steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (r_state == F_IDLE && i_valid) begin
            r_step <= STEP_W'(MOD_STEPS - 1);
        end else if (r_state == F_MOD) begin
            r_step <= r_step - STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) begin
            r_pa    <= i_pulse_height_a;
            r_pb    <= i_pulse_height_b;
            r_sx    <= i_slope_x;
            r_sy    <= i_slope_y;
            r_plate <= i_plate;
            r_last  <= i_last_segment;
        end else if (r_state == F_MOD) begin
            if (r_step != '0) begin
                r_qa <= qa_prod[PROD_W-1:RECIP_SH];
                r_qb <= qb_prod[PROD_W-1:RECIP_SH];
            end else begin
                r_pa <= pa_nxt;
                r_pb <= pb_nxt;
            end
        end
    end

    // chain sums, cleared after the last segment is handed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_sum    <= '0;
            r_sq     <= '0;
            r_sx_sum <= '0;
            r_sy_sum <= '0;
            r_first  <= '0;
            r_ovf    <= 1'b0;
        end else if (acc_go) begin
            if (r_last) begin
                r_cnt    <= '0;
                r_sum    <= '0;
                r_sq     <= '0;
                r_sx_sum <= '0;
                r_sy_sum <= '0;
                r_first  <= '0;
                r_ovf    <= 1'b0;
            end else begin
                r_cnt    <= a_cnt;
                r_sum    <= a_sum;
                r_sq     <= a_sq;
                r_sx_sum <= a_sx;
                r_sy_sum <= a_sy;
                r_first  <= a_first;
                r_ovf    <= a_ovf;
            end
        end
    end

endmodule

// File: rtl/thph_back.sv
// ============================================================================
// thph_back
// Per chain statistics: variance, means, angle and deviation, then result.
// ============================================================================
module thph_back #(
    parameter int MAX_SEGMENTS = thph_pkg::MAX_SEGMENTS_DEF,
    parameter int CNT_W  = $clog2(MAX_SEGMENTS + 1),
    parameter int SUM_W  = thph_pkg::PHS_W + CNT_W,
    parameter int SQ_W   = thph_pkg::PHSQ_W + CNT_W,
    parameter int SS_W   = thph_pkg::SLOPE_W + CNT_W,
    parameter int SNAP_W = 1 + CNT_W + thph_pkg::SPAN_W + SUM_W + SQ_W + 2 * SS_W
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_snap_valid,
    input  logic [SNAP_W-1:0]                  i_snap,
    output logic                               o_pop,
    input  logic [thph_pkg::MINC_W-1:0]        i_min_count,
    input  logic [thph_pkg::VFLOOR_W-1:0]      i_var_floor,
    output logic                               o_tvalid,
    input  logic                               i_tready,
    output logic [thph_pkg::OUT_TDATA_W-1:0]   o_tdata
);
    import thph_pkg::*;

    localparam int NQ_W    = SQ_W + CNT_W;
    localparam int NSQ_W   = 2 * SUM_W;
    localparam int DVD_W   = NQ_W + 16;
    localparam int DVS_W   = 2 * CNT_W;
    localparam int SQ_IN_W = DVD_W + (DVD_W % 2);
    localparam int RT_W    = SQ_IN_W / 2;
    localparam int MC_W    = $clog2(CNT_W);
    localparam int CMP_W   = (CNT_W > MINC_W) ? CNT_W : MINC_W;
    localparam int SL2_W   = 2 * SLOPE_W;

    t_back_state r_state;
    t_back_state n_state;

    // snapshot fields
    logic                   s_ovf;
    logic [CNT_W-1:0]       s_n;
    logic [SPAN_W-1:0]      s_span;
    logic [SUM_W-1:0]       s_sum;
    logic [SQ_W-1:0]        s_sq;
    logic signed [SS_W-1:0] s_sx;
    logic signed [SS_W-1:0] s_sy;

    logic [CNT_W-1:0]       r_n;
    logic [SPAN_W-1:0]      r_span;
    logic [SUM_W-1:0]       r_sum;
    logic signed [SS_W-1:0] r_sx;
    logic signed [SS_W-1:0] r_sy;

    // n * sum of squares by shift and add
    logic [NQ_W-1:0]        r_mq;
    logic [CNT_W-1:0]       r_mn;
    logic [MC_W-1:0]        r_mcnt;
    logic [NQ_W-1:0]        r_nq;
    logic [NSQ_W-1:0]       r_ssq;
    logic [DVS_W-1:0]       r_nn;
    logic [DVS_W-1:0]       r_m;
    logic [NQ_W-1:0]        r_dev;

    logic [DVD_W-1:0]       r_var;
    logic [MEAN_W-1:0]      r_mean;
    logic [SLOPE_W-1:0]     r_mx_mag;
    logic [SLOPE_W-1:0]     r_my_mag;
    logic                   r_mx_neg;
    logic                   r_my_neg;
    logic [ANGLE_W-1:0]     r_angle;
    logic [SD_W-1:0]        r_sd;
    t_status                r_status;

    // shared unit requests
    logic                   r_div_go;
    logic [DVD_W-1:0]       r_div_a;
    logic [DVS_W-1:0]       r_div_b;
    logic                   r_sq_go;
    logic [SQ_IN_W-1:0]     r_sq_a;
    logic                   div_done;
    logic [DVD_W-1:0]       div_quot;
    logic                   sq_done;
    logic [RT_W-1:0]        sq_root;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [NQ_W-1:0]        dev_c;
    logic [DVS_W-1:0]       m_c;
    logic [SS_W-1:0]        sx_mag;
    logic [SS_W-1:0]        sy_mag;
    logic [SL2_W-1:0]       mx2;
    logic [SL2_W-1:0]       my2;
    logic [SLOPE_W-1:0]     mx_out;
    logic [SLOPE_W-1:0]     my_out;
    logic                   out_load;
    logic                   few;
    logic                   lowvar;

    assign {s_ovf, s_n, s_span, s_sum, s_sq, s_sx, s_sy} = i_snap;

    thph_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_div_a),
        .i_divisor  (r_div_b),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    thph_sqrt #(
        .IN_W (SQ_IN_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sq_go),
        .i_radicand (r_sq_a),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    // helper arithmetic
    always_comb begin
        dev_c  = (r_nq > NQ_W'(r_ssq)) ? r_nq - NQ_W'(r_ssq) : '0;
        m_c    = DVS_W'(r_n) * DVS_W'(r_n - CNT_W'(1));
        sx_mag = r_sx[SS_W-1] ? SS_W'(-r_sx) : SS_W'(r_sx);
        sy_mag = r_sy[SS_W-1] ? SS_W'(-r_sy) : SS_W'(r_sy);
        mx2    = {{SLOPE_W{1'b0}}, r_mx_mag} * {{SLOPE_W{1'b0}}, r_mx_mag};
        my2    = {{SLOPE_W{1'b0}}, r_my_mag} * {{SLOPE_W{1'b0}}, r_my_mag};
        mx_out = r_mx_neg ? SLOPE_W'(-r_mx_mag) : r_mx_mag;
        my_out = r_my_neg ? SLOPE_W'(-r_my_mag) : r_my_mag;
        few    = (CMP_W'(r_n) <= CMP_W'(i_min_count));
        lowvar = (r_var <= DVD_W'(i_var_floor));
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_snap_valid) begin
                    o_pop   = 1'b1;
                    n_state = s_ovf ? B_DONE : B_MUL;
                end
            end
            B_MUL: begin
                if (r_mcnt == '0) begin
                    n_state = B_DEV;
                end
            end
            B_DEV: begin
                n_state = B_DIV_VAR;
            end
            B_DIV_VAR: begin
                if (div_done) begin
                    n_state = B_DIV_MEAN;
                end
            end
            B_DIV_MEAN: begin
                if (div_done) begin
                    n_state = B_DIV_MX;
                end
            end
            B_DIV_MX: begin
                if (div_done) begin
                    n_state = B_DIV_MY;
                end
            end
            B_DIV_MY: begin
                if (div_done) begin
                    n_state = B_ANG_SQ;
                end
            end
            B_ANG_SQ: begin
                n_state = B_SQRT_ANG;
            end
            B_SQRT_ANG: begin
                if (sq_done) begin
                    n_state = (few || lowvar) ? B_DONE : B_DIV_SD;
                end
            end
            B_DIV_SD: begin
                if (div_done) begin
                    n_state = B_SQRT_SD;
                end
            end
            B_SQRT_SD: begin
                if (sq_done) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (!r_out_valid || i_tready) begin
                    out_load = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // unit start pulses
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_go <= 1'b0;
            r_sq_go  <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            r_sq_go  <= 1'b0;
            unique case (r_state)
                B_DEV:      r_div_go <= 1'b1;
                B_DIV_VAR,
                B_DIV_MEAN,
                B_DIV_MX:   r_div_go <= div_done;
                B_ANG_SQ:   r_sq_go  <= 1'b1;
                B_SQRT_ANG: r_div_go <= sq_done && !few && !lowvar;
                B_DIV_SD:   r_sq_go  <= div_done;
                default: begin
                    r_div_go <= 1'b0;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (i_snap_valid) begin
                    r_n      <= s_n;
                    r_span   <= s_span;
                    r_sum    <= s_sum;
                    r_sx     <= s_sx;
                    r_sy     <= s_sy;
                    r_mq     <= NQ_W'(s_sq);
                    r_mn     <= s_n;
                    r_mcnt   <= MC_W'(CNT_W - 1);
                    r_nq     <= '0;
                    r_mean   <= '0;
                    r_mx_mag <= '0;
                    r_my_mag <= '0;
                    r_mx_neg <= 1'b0;
                    r_my_neg <= 1'b0;
                    r_angle  <= '0;
                    r_sd     <= '0;
                    r_status <= s_ovf ? ST_MANY : ST_KEPT;
                end
            end
            B_MUL: begin
                if (r_mn[0]) begin
                    r_nq <= r_nq + r_mq;
                end
                r_mq   <= {r_mq[NQ_W-2:0], 1'b0};
                r_mn   <= r_mn >> 1;
                r_mcnt <= r_mcnt - MC_W'(1);
                r_ssq  <= {{SUM_W{1'b0}}, r_sum} * {{SUM_W{1'b0}}, r_sum};
                r_nn   <= DVS_W'(r_n) * DVS_W'(r_n);
                r_m    <= (m_c == '0) ? DVS_W'(1) : m_c;
            end
            B_DEV: begin
                r_dev   <= dev_c;
                r_div_a <= {dev_c, 16'h0000} >> 8;
                r_div_b <= r_nn;
            end
            B_DIV_VAR: begin
                if (div_done) begin
                    r_var   <= div_quot;
                    r_div_a <= DVD_W'({r_sum, 8'h00}) + DVD_W'(r_n >> 1);
                    r_div_b <= DVS_W'(r_n);
                end
            end
            B_DIV_MEAN: begin
                if (div_done) begin
                    r_mean  <= div_quot[MEAN_W-1:0];
                    r_div_a <= DVD_W'(sx_mag) + DVD_W'(r_n >> 1);
                end
            end
            B_DIV_MX: begin
                if (div_done) begin
                    r_mx_mag <= div_quot[SLOPE_W-1:0];
                    r_mx_neg <= r_sx[SS_W-1];
                    r_div_a  <= DVD_W'(sy_mag) + DVD_W'(r_n >> 1);
                end
            end
            B_DIV_MY: begin
                if (div_done) begin
                    r_my_mag <= div_quot[SLOPE_W-1:0];
                    r_my_neg <= r_sy[SS_W-1];
                end
            end
            B_ANG_SQ: begin
                r_sq_a <= SQ_IN_W'(mx2) + SQ_IN_W'(my2);
            end
            B_SQRT_ANG: begin
                if (sq_done) begin
                    r_angle <= sq_root[ANGLE_W-1:0];
                    if (few) begin
                        r_status <= ST_FEW;
                    end else if (lowvar) begin
                        r_status <= ST_LOWVAR;
                    end
                    r_div_a <= {r_dev, 16'h0000};
                    r_div_b <= r_m;
                end
            end
            B_DIV_SD: begin
                if (div_done) begin
                    r_sq_a <= SQ_IN_W'(div_quot);
                end
            end
            B_SQRT_SD: begin
                if (sq_done) begin
                    r_sd <= (sq_root > RT_W'(SD_MAX)) ? SD_MAX : sq_root[SD_W-1:0];
                end
            end
            default: begin
                r_status <= r_status;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, r_angle, my_out, mx_out, r_sd, r_mean,
                           r_span, COUNT_W'(r_n), r_status};
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;

endmodule
